// File: hw/rtl/sscu_pkg.sv
// ----------------------------------------------------------------------------
// Sprite sheet cell UV package
// Shared types, register indexes and constants of the sprite sheet cell unit.
// ----------------------------------------------------------------------------
package sscu_pkg;

  localparam int unsigned FractionBits = 16;
  localparam int unsigned CoordWidth   = 17;
  localparam int unsigned CfgIdxWidth  = 3;

  localparam logic [CfgIdxWidth-1:0] CfgSheetWidth    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgSheetHeight   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgCellWidth     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgCellHeight    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgTextureHandle = 3'd4;

  localparam logic [15:0] SizeReset   = 16'd1;
  localparam logic [31:0] HandleReset = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic [31:0] cell_index;
    logic        flipped;
  } req_t;

  typedef struct packed {
    logic [CoordWidth-1:0] corner0_u;
    logic [CoordWidth-1:0] corner0_v;
    logic [CoordWidth-1:0] corner1_u;
    logic [CoordWidth-1:0] corner1_v;
    logic [CoordWidth-1:0] corner2_u;
    logic [CoordWidth-1:0] corner2_v;
    logic [CoordWidth-1:0] corner3_u;
    logic [CoordWidth-1:0] corner3_v;
    logic [31:0]           result_handle;
    logic [15:0]           result_cell_width;
    logic [15:0]           result_cell_height;
  } rsp_t;

endpackage

// File: hw/rtl/sscu_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One registered restoring division step; hands its word to the next cell.
// ----------------------------------------------------------------------------
module sscu_div_cell #(
  parameter int unsigned RW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [RW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] quo_o,
  output logic [RW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [RW+1:0] diff;
  logic          take;
  logic [RW-1:0] rem_d, rem_q;
  logic [QW-1:0] quo_d, quo_q;
  logic [RW-1:0] den_q;
  logic [SW-1:0] side_q;
  logic          valid_q;

  // The partial remainder stays below the divisor, so one trial subtract
  // decides each quotient bit.
  always_comb begin
    diff  = {1'b0, rem_i, quo_i[QW-1]} - {2'b00, den_i};
    take  = ~diff[RW+1];
    rem_d = take ? diff[RW-1:0] : {rem_i[RW-2:0], quo_i[QW-1]};
    quo_d = {quo_i[QW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// File: hw/rtl/sscu_div_chain.sv
// ----------------------------------------------------------------------------
// Divider chain
// A row of divider cells, one quotient bit per cell and per cycle while en_i is high.
// ----------------------------------------------------------------------------
module sscu_div_chain #(
  parameter int unsigned RW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [RW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] quo_o,
  output logic [RW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic          v_w    [QW+1];
  logic [RW-1:0] rem_w  [QW+1];
  logic [QW-1:0] quo_w  [QW+1];
  logic [RW-1:0] den_w  [QW+1];
  logic [SW-1:0] side_w [QW+1];

  assign v_w[0]    = valid_i;
  assign rem_w[0]  = rem_i;
  assign quo_w[0]  = quo_i;
  assign den_w[0]  = den_i;
  assign side_w[0] = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sscu_div_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v_w[i]),
      .rem_i   (rem_w[i]),
      .quo_i   (quo_w[i]),
      .den_i   (den_w[i]),
      .side_i  (side_w[i]),
      .valid_o (v_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .quo_o   (quo_w[i+1]),
      .den_o   (den_w[i+1]),
      .side_o  (side_w[i+1])
    );
  end

  assign valid_o = v_w[QW];
  assign rem_o   = rem_w[QW];
  assign quo_o   = quo_w[QW];
  assign den_o   = den_w[QW];
  assign side_o  = side_w[QW];

endmodule

// File: hw/rtl/sprite_sheet_cell_uv_unit.sv
// ----------------------------------------------------------------------------
// Sprite sheet cell UV unit
// Maps a sprite request to the four normalized corners of one sheet cell.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Payload
//   request   in         in_valid_i / in_ready_o   in_data_i  (sscu_pkg::req_t)
//   result    out        out_valid_o / out_ready_i out_data_o (sscu_pkg::rsp_t)
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction is accepted per cycle while the skid register is empty.
// Three chains of divider cells make up the pipeline: 16 cells for the
// cells-per-row and per-column counts, 32 cells for splitting a linear
// index, and FRACTION_BITS cells for the corner fractions, plus five stages
// of single registers. Reset clears all valid flags and loads the register reset values.
// The pipeline stalls only when the output skid register is occupied, so a
// result waiting on the output never blocks new requests by itself.
// Configuration writes are always accepted.
//
module sprite_sheet_cell_uv_unit #(
  parameter int unsigned FRACTION_BITS = sscu_pkg::FractionBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sscu_pkg::req_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sscu_pkg::rsp_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sscu_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int unsigned VW = FRACTION_BITS + 1;
  localparam logic [VW-1:0] One = VW'(1) << FRACTION_BITS;

  // Configuration registers. The user must change them only while no transaction
  // is in flight; the block does not enforce this. Every stage reads them directly.
  logic [15:0] sw_q, sh_q, cw_q, ch_q;
  logic [31:0] handle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= sscu_pkg::SizeReset;
      sh_q     <= sscu_pkg::SizeReset;
      cw_q     <= sscu_pkg::SizeReset;
      ch_q     <= sscu_pkg::SizeReset;
      handle_q <= sscu_pkg::HandleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sscu_pkg::CfgSheetWidth:    sw_q     <= cfg_data_i[15:0];
        sscu_pkg::CfgSheetHeight:   sh_q     <= cfg_data_i[15:0];
        sscu_pkg::CfgCellWidth:     cw_q     <= cfg_data_i[15:0];
        sscu_pkg::CfgCellHeight:    ch_q     <= cfg_data_i[15:0];
        sscu_pkg::CfgTextureHandle: handle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A size of zero counts as one everywhere except in the copied fields.
  logic [15:0] sw_nz, sh_nz, cw_nz, ch_nz;
  assign sw_nz = (sw_q == '0) ? 16'd1 : sw_q;
  assign sh_nz = (sh_q == '0) ? 16'd1 : sh_q;
  assign cw_nz = (cw_q == '0) ? 16'd1 : cw_q;
  assign ch_nz = (ch_q == '0) ? 16'd1 : ch_q;

  // Global advance: held only while the skid register is full.
  logic en;
  logic skid_valid_q;
  assign en         = ~skid_valid_q;
  assign in_ready_o = en;

  // Stage A: cells per row and per column.
  logic           a_row_v, a_col_v;
  logic [15:0]    a_row_q, a_col_q;
  sscu_pkg::req_t a_req;
  logic           a_flip;

  sscu_div_chain #(.RW(16), .QW(16), .SW($bits(sscu_pkg::req_t))) u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .rem_i   (16'd0),
    .quo_i   (sw_nz),
    .den_i   (cw_nz),
    .side_i  (in_data_i),
    .valid_o (a_row_v),
    .rem_o   (),
    .quo_o   (a_row_q),
    .den_o   (),
    .side_o  (a_req)
  );

  sscu_div_chain #(.RW(16), .QW(16), .SW(1)) u_col_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .rem_i   (16'd0),
    .quo_i   (sh_nz),
    .den_i   (ch_nz),
    .side_i  (in_data_i.flipped),
    .valid_o (a_col_v),
    .rem_o   (),
    .quo_o   (a_col_q),
    .den_o   (),
    .side_o  (a_flip)
  );

  // Stage B: forced counts and the total cell count.
  logic [15:0] pr_nz, pc_nz;
  assign pr_nz = (a_row_q == '0) ? 16'd1 : a_row_q;
  assign pc_nz = (a_col_q == '0) ? 16'd1 : a_col_q;

  logic           b_v_q;
  logic [15:0]    b_pr_q, b_pc_q;
  logic [31:0]    b_cnt_q;
  sscu_pkg::req_t b_req_q;
  logic           b_flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_row_v & a_col_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_pr_q   <= pr_nz;
      b_pc_q   <= pc_nz;
      b_cnt_q  <= 32'(pr_nz) * 32'(pc_nz);
      b_req_q  <= a_req;
      b_flip_q <= a_flip;
    end
  end

  // Stage C: clamp the index and split it by the cells-per-row count.
  typedef struct packed {
    logic        mode;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic        flipped;
    logic [15:0] per_col;
  } split_t;

  logic [31:0] idx_c;
  split_t      c_side_in, c_side;
  logic        c_v;
  logic [15:0] c_rem, c_pr;
  logic [31:0] c_quo;

  assign idx_c = (b_req_q.cell_index >= b_cnt_q) ? (b_cnt_q - 32'd1) : b_req_q.cell_index;

  always_comb begin
    c_side_in.mode    = b_req_q.mode;
    c_side_in.cell_x  = b_req_q.cell_x;
    c_side_in.cell_y  = b_req_q.cell_y;
    c_side_in.flipped = b_flip_q;
    c_side_in.per_col = b_pc_q;
  end

  sscu_div_chain #(.RW(16), .QW(32), .SW($bits(split_t))) u_idx_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .rem_i   (16'd0),
    .quo_i   (idx_c),
    .den_i   (b_pr_q),
    .side_i  (c_side_in),
    .valid_o (c_v),
    .rem_o   (c_rem),
    .quo_o   (c_quo),
    .den_o   (c_pr),
    .side_o  (c_side)
  );

  // Stage D: pick the position, clamp it and count rows from the far edge.
  logic [15:0] x_sel, y_sel, x_cl, y_cl;
  always_comb begin
    x_sel = c_side.mode ? c_rem : c_side.cell_x;
    y_sel = c_side.mode ? c_quo[15:0] : c_side.cell_y;
    x_cl  = (x_sel >= c_pr) ? (c_pr - 16'd1) : x_sel;
    y_cl  = (y_sel >= c_side.per_col) ? (c_side.per_col - 16'd1) : y_sel;
  end

  logic        d_v_q, d_flip_q;
  logic [15:0] d_x_q, d_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= c_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_x_q    <= x_cl;
      d_y_q    <= c_side.per_col - 16'd1 - y_cl;
      d_flip_q <= c_side.flipped;
    end
  end

  // Stage E: texel offsets of the near edges.
  logic        e_v_q, e_flip_q;
  logic [31:0] e_pu_q, e_pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_pu_q   <= 32'(cw_nz) * 32'(d_x_q);
      e_pv_q   <= 32'(ch_nz) * 32'(d_y_q);
      e_flip_q <= d_flip_q;
    end
  end

  // Stage F: far edges, saturation test and the starting remainders. An
  // offset at or past the sheet size gives exactly 1.0; otherwise it is below
  // the divisor and the fraction bits come from the next chain.
  logic [31:0] pu1, pv1;
  assign pu1 = e_pu_q + {16'd0, cw_nz};
  assign pv1 = e_pv_q + {16'd0, ch_nz};

  logic        f_v_q, f_flip_q;
  logic [3:0]  f_sat_q;
  logic [15:0] f_rem_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_sat_q[0] <= e_pu_q >= {16'd0, sw_nz};
      f_sat_q[1] <= pu1    >= {16'd0, sw_nz};
      f_sat_q[2] <= e_pv_q >= {16'd0, sh_nz};
      f_sat_q[3] <= pv1    >= {16'd0, sh_nz};
      f_rem_q[0] <= (e_pu_q >= {16'd0, sw_nz}) ? 16'd0 : e_pu_q[15:0];
      f_rem_q[1] <= (pu1    >= {16'd0, sw_nz}) ? 16'd0 : pu1[15:0];
      f_rem_q[2] <= (e_pv_q >= {16'd0, sh_nz}) ? 16'd0 : e_pv_q[15:0];
      f_rem_q[3] <= (pv1    >= {16'd0, sh_nz}) ? 16'd0 : pv1[15:0];
      f_flip_q   <= e_flip_q;
    end
  end

  // Stage G: the four fraction chains run side by side.
  logic                     g_v;
  logic [FRACTION_BITS-1:0] g_quo [4];
  logic [1:0]               g_side [4];
  logic [VW-1:0]            g_val [4];

  for (genvar k = 0; k < 4; k++) begin : g_frac
    if (k == 0) begin : g_lead
      sscu_div_chain #(.RW(16), .QW(FRACTION_BITS), .SW(2)) u_frac_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (f_v_q),
        .rem_i   (f_rem_q[k]),
        .quo_i   ({FRACTION_BITS{1'b0}}),
        .den_i   (sw_nz),
        .side_i  ({f_flip_q, f_sat_q[k]}),
        .valid_o (g_v),
        .rem_o   (),
        .quo_o   (g_quo[k]),
        .den_o   (),
        .side_o  (g_side[k])
      );
    end else begin : g_rest
      sscu_div_chain #(.RW(16), .QW(FRACTION_BITS), .SW(2)) u_frac_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (f_v_q),
        .rem_i   (f_rem_q[k]),
        .quo_i   ({FRACTION_BITS{1'b0}}),
        .den_i   ((k < 2) ? sw_nz : sh_nz),
        .side_i  ({f_flip_q, f_sat_q[k]}),
        .valid_o (),
        .rem_o   (),
        .quo_o   (g_quo[k]),
        .den_o   (),
        .side_o  (g_side[k])
      );
    end
    assign g_val[k] = g_side[k][0] ? One : {1'b0, g_quo[k]};
  end

  // Corner assembly; flipping swaps the near and far V coordinates.
  sscu_pkg::rsp_t rsp;
  logic [VW-1:0]  v_near, v_far;

  always_comb begin
    v_near = g_side[0][1] ? g_val[3] : g_val[2];
    v_far  = g_side[0][1] ? g_val[2] : g_val[3];
    rsp.corner0_u          = sscu_pkg::CoordWidth'(g_val[0]);
    rsp.corner0_v          = sscu_pkg::CoordWidth'(v_near);
    rsp.corner1_u          = sscu_pkg::CoordWidth'(g_val[0]);
    rsp.corner1_v          = sscu_pkg::CoordWidth'(v_far);
    rsp.corner2_u          = sscu_pkg::CoordWidth'(g_val[1]);
    rsp.corner2_v          = sscu_pkg::CoordWidth'(v_far);
    rsp.corner3_u          = sscu_pkg::CoordWidth'(g_val[1]);
    rsp.corner3_v          = sscu_pkg::CoordWidth'(v_near);
    rsp.result_handle      = handle_q;
    rsp.result_cell_width  = cw_q;
    rsp.result_cell_height = ch_q;
  end

  // Output register with a skid stage behind it.
  logic           out_valid_q;
  sscu_pkg::rsp_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= g_v;
    end else if (g_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_q <= rsp;
    end else begin
      skid_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
